// ----- design/snap_pkg.sv -----
// Shared types and codes for the snap candidate selector.
// Holds the stored entry layout, the sequencer states and the command and register codes.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package snap_pkg;

  // Command codes carried on func.
  localparam logic [1:0] FUNC_CONSIDER = 2'd0;
  localparam logic [1:0] FUNC_RESOLVE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR    = 2'd2;

  // Register indexes on the configuration port (byte address bits 3:2).
  localparam logic [1:0] REG_KIND_MASK = 2'd0;
  localparam logic [1:0] REG_APER_MAX  = 2'd1;
  localparam logic [1:0] REG_APER_MIN  = 2'd2;
  localparam logic [1:0] REG_DPI_SCALE = 2'd3;

  // Reset values of the registers.
  localparam logic [31:0] KIND_MASK_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] APER_MAX_RST  = 16'd4096;
  localparam logic [15:0] APER_MIN_RST  = 16'd1024;
  localparam logic [11:0] DPI_SCALE_RST = 12'd256;

  // A zero scale is taken as 1.0 in Q4.8.
  localparam logic [11:0] DPI_SCALE_ONE = 12'd256;

  // One stored candidate per priority level.
  typedef struct packed {
    logic [23:0] dist_val;
    logic [4:0]  kind;
    logic [7:0]  prio;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [63:0] obj;
    logic [63:0] partner;
  } entry_t;

  // Configuration seen by the aperture unit.
  typedef struct packed {
    logic [15:0] aper_max;
    logic [15:0] aper_min;
    logic [11:0] dpi_scale;
  } aper_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AP1,
    ST_AP2,
    ST_AP3,
    ST_DEC,
    ST_RES
  } state_t;

endpackage

`default_nettype wire

// ----- design/snap_mem.sv -----
// Entry store of the snap candidate selector: one entry per priority level.
// One write port and one read port with registered read data; uses snap_pkg::entry_t.
`default_nettype none

module snap_mem #(
  parameter int LEVELS = 16
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [$clog2(LEVELS)-1:0]    wr_addr,
  input  snap_pkg::entry_t             wr_data,
  input  wire                          rd_en,
  input  wire  [$clog2(LEVELS)-1:0]    rd_addr,
  output snap_pkg::entry_t             rd_data
);

  snap_pkg::entry_t mem [LEVELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/snap_aper.sv -----
// Aperture threshold pipeline: level and configuration in, Q12.16 distance limit out.
// Divides by the constant LEVELS-2 through a reciprocal multiply with one correction step.
// Uses snap_pkg::aper_cfg_t; a loaded value passes registers p, q0, q, then limit.
`default_nettype none

module snap_aper #(
  parameter int LEVELS = 16
) (
  input  wire                          clk,
  input  wire                          load,
  input  wire  [$clog2(LEVELS)-1:0]    level,
  input  snap_pkg::aper_cfg_t          cfg,
  output logic [27:0]                  limit
);

  localparam int LW  = $clog2(LEVELS);
  localparam int PW  = LW + 16;
  localparam int DIV = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int DW  = $clog2(DIV + 1);
  localparam logic [PW:0] RECIP = (PW+1)'((64'd1 << PW) / DIV);

  logic signed [16:0] diff;
  logic [16:0]        ndiff;
  logic [15:0]        absdiff;
  logic [LW-1:0]      lvl_m1;
  logic [PW-1:0]      prod_c;
  logic [2*PW:0]      qprod;
  logic [PW+DW-1:0]   qd;
  logic               fix;
  logic [15:0]        aper;
  logic [11:0]        scale;

  logic [PW-1:0]      p;
  logic               neg;
  logic [PW-1:0]      q0;
  logic [PW-1:0]      q;

  always_comb begin
    diff    = $signed({1'b0, cfg.aper_max}) - $signed({1'b0, cfg.aper_min});
    ndiff   = 17'(-diff);
    absdiff = diff[16] ? ndiff[15:0] : diff[15:0];
    lvl_m1  = level - LW'(1);
    prod_c  = PW'(lvl_m1) * PW'(absdiff);
    qprod   = (2*PW+1)'(p) * (2*PW+1)'(RECIP);
    qd      = (PW+DW)'(q0) * (PW+DW)'(DIV);
    fix     = (PW+DW)'(p) >= (qd + (PW+DW)'(DIV));
    // The quotient never exceeds the magnitude of the difference, so 16 bits hold it.
    aper    = neg ? (cfg.aper_max + q[15:0]) : (cfg.aper_max - q[15:0]);
    scale   = (cfg.dpi_scale == 12'd0) ? snap_pkg::DPI_SCALE_ONE : cfg.dpi_scale;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p   <= prod_c;
      neg <= diff[16];
    end
    q0    <= qprod[2*PW-1:PW];
    q     <= fix ? (q0 + PW'(1)) : q0;
    limit <= 28'(aper) * 28'(scale);
  end

endmodule

`default_nettype wire

// ----- design/snap_candidate_selector_unit.sv -----
// Top level of the snap candidate selector: command port, APB register file and sequencer.
// Instantiates snap_aper (threshold pipeline) and snap_mem (per-level entry store).
// Depends on snap_pkg for entry layout, states and codes.
`default_nettype none

// Channel    Direction  Handshake                         Payload
// command    in         start && !busy at a rising edge   func, kind, priority_req,
//                                                          coord_x/y/z, object_id,
//                                                          partner_id, distance
// result     out        done high for one cycle           hit, out_kind, out_priority,
//                                                          out_x/y/z, out_object, out_partner
// config     in/out     psel && penable && pwrite         paddr, pwdata, prdata, pready
//
// A consider item that passes the kind and level checks keeps busy high after it is accepted
// until it has gone through the three multiplier stages of the aperture pipeline and the
// decide-and-write cycle on the entry store; no new item is taken before that write.
// A resolve item keeps busy high for one cycle while the entry store is read; its result
// is shown in the next cycle, in which a new item may already be accepted.
// Clear, an unused func and a consider item dropped on kind or level keep busy low.
// Reset is synchronous and clears the level valid bits; no clearing pass is needed,
// since an entry's data is used only while its valid bit is set. The receiver cannot stall.

module snap_candidate_selector_unit #(
  parameter int LEVELS = 16
) (
  input  wire                 clk,
  input  wire                 rst,

  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          func,
  input  wire  [4:0]          kind,
  input  wire  [7:0]          priority_req,
  input  wire  signed [31:0]  coord_x,
  input  wire  signed [31:0]  coord_y,
  input  wire  signed [31:0]  coord_z,
  input  wire  [63:0]         object_id,
  input  wire  [63:0]         partner_id,
  input  wire  [23:0]         distance,

  output logic                done,
  output logic                hit,
  output logic [4:0]          out_kind,
  output logic [7:0]          out_priority,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [63:0]         out_object,
  output logic [63:0]         out_partner,

  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LW = $clog2(LEVELS);

  // Configuration registers.
  logic [31:0] kind_mask;
  logic [15:0] aper_max;
  logic [15:0] aper_min;
  logic [11:0] dpi_scale;

  snap_pkg::state_t    state;
  snap_pkg::state_t    state_next;

  logic [LEVELS-1:0]   level_valid;
  snap_pkg::entry_t    req;
  logic [LW-1:0]       req_lvl;
  logic                res_hit;

  logic                accept;
  logic                cfg_wr;
  logic [LW-1:0]       in_lvl;
  logic                eligible;
  logic [LW-1:0]       top_lvl;
  logic                any_valid;
  logic                keep;

  logic                mem_rd_en;
  logic [LW-1:0]       mem_rd_addr;
  logic                mem_wr_en;
  snap_pkg::entry_t    mem_rd_data;
  snap_pkg::entry_t    in_entry;
  snap_pkg::aper_cfg_t aper_cfg;
  logic [27:0]         limit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = start && !busy;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_mask <= snap_pkg::KIND_MASK_RST;
      aper_max  <= snap_pkg::APER_MAX_RST;
      aper_min  <= snap_pkg::APER_MIN_RST;
      dpi_scale <= snap_pkg::DPI_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        snap_pkg::REG_KIND_MASK: kind_mask <= pwdata;
        snap_pkg::REG_APER_MAX:  aper_max  <= pwdata[15:0];
        snap_pkg::REG_APER_MIN:  aper_min  <= pwdata[15:0];
        snap_pkg::REG_DPI_SCALE: dpi_scale <= pwdata[11:0];
        default:                 kind_mask <= kind_mask;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      snap_pkg::REG_KIND_MASK: prdata = kind_mask;
      snap_pkg::REG_APER_MAX:  prdata = {16'd0, aper_max};
      snap_pkg::REG_APER_MIN:  prdata = {16'd0, aper_min};
      snap_pkg::REG_DPI_SCALE: prdata = {20'd0, dpi_scale};
      default:                 prdata = 32'd0;
    endcase
  end

  // The offered priority is clamped to the top level; level zero is the ambient grid
  // and is never stored.
  always_comb begin
    in_lvl   = (priority_req >= 8'(LEVELS - 1)) ? LW'(LEVELS - 1) : priority_req[LW-1:0];
    eligible = (kind != 5'd0) && kind_mask[kind] && (in_lvl != LW'(0));
    in_entry.dist_val = distance;
    in_entry.kind     = kind;
    in_entry.prio     = priority_req;
    in_entry.x        = $unsigned(coord_x);
    in_entry.y        = $unsigned(coord_y);
    in_entry.z        = $unsigned(coord_z);
    in_entry.obj      = object_id;
    in_entry.partner  = partner_id;
  end

  // Highest valid level; the last match of the ascending scan wins.
  always_comb begin
    top_lvl = LW'(0);
    for (int i = 1; i < LEVELS; i++) begin
      if (level_valid[i]) begin
        top_lvl = LW'(i);
      end
    end
    any_valid = |level_valid;
  end

  function automatic logic [31:0] distance_q(input logic [23:0] d);
    distance_q = {d, 8'd0};
  endfunction

  // A candidate is kept when it lies inside the scaled aperture and is strictly nearer
  // than what its level holds. The distance gets 8 more fraction bits to meet Q12.16.
  assign keep = ({distance_q(req.dist_val)} <= {4'd0, limit}) &&
                (!level_valid[req_lvl] || (req.dist_val < mem_rd_data.dist_val));

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      snap_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (func == snap_pkg::FUNC_CONSIDER && eligible) begin
            state_next = snap_pkg::ST_AP1;
          end else if (func == snap_pkg::FUNC_RESOLVE) begin
            state_next = snap_pkg::ST_RES;
          end else begin
            state_next = snap_pkg::ST_IDLE;
          end
        end
      end
      snap_pkg::ST_AP1: state_next = snap_pkg::ST_AP2;
      snap_pkg::ST_AP2: state_next = snap_pkg::ST_AP3;
      snap_pkg::ST_AP3: state_next = snap_pkg::ST_DEC;
      snap_pkg::ST_DEC: state_next = snap_pkg::ST_IDLE;
      snap_pkg::ST_RES: state_next = snap_pkg::ST_IDLE;
      default:          state_next = snap_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs. The store is read at acceptance and written only in the decide
  // cycle; busy keeps the next item out until that write has landed, so a later read of
  // the same level always sees it.
  always_comb begin
    busy        = (state != snap_pkg::ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = in_lvl;
    mem_wr_en   = 1'b0;
    if (state == snap_pkg::ST_IDLE && accept) begin
      mem_rd_en   = (func == snap_pkg::FUNC_CONSIDER) || (func == snap_pkg::FUNC_RESOLVE);
      mem_rd_addr = (func == snap_pkg::FUNC_RESOLVE) ? top_lvl : in_lvl;
    end
    if (state == snap_pkg::ST_DEC) begin
      mem_wr_en = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Valid bits: clear empties every level at once, a kept candidate marks its level.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= '0;
    end else if (accept && func == snap_pkg::FUNC_CLEAR) begin
      level_valid <= '0;
    end else if (mem_wr_en) begin
      level_valid[req_lvl] <= 1'b1;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= in_entry;
      req_lvl <= in_lvl;
      res_hit <= any_valid;
    end
  end

  // Result registers; an empty resolve reports zeros in every field.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == snap_pkg::ST_RES);
    end
  end

  always_ff @(posedge clk) begin
    if (state == snap_pkg::ST_RES) begin
      hit          <= res_hit;
      out_kind     <= res_hit ? mem_rd_data.kind    : 5'd0;
      out_priority <= res_hit ? mem_rd_data.prio    : 8'd0;
      out_x        <= res_hit ? $signed(mem_rd_data.x) : 32'sd0;
      out_y        <= res_hit ? $signed(mem_rd_data.y) : 32'sd0;
      out_z        <= res_hit ? $signed(mem_rd_data.z) : 32'sd0;
      out_object   <= res_hit ? mem_rd_data.obj     : 64'd0;
      out_partner  <= res_hit ? mem_rd_data.partner : 64'd0;
    end
  end

  assign aper_cfg.aper_max  = aper_max;
  assign aper_cfg.aper_min  = aper_min;
  assign aper_cfg.dpi_scale = dpi_scale;

  snap_aper #(
    .LEVELS(LEVELS)
  ) u_aper (
    .clk   (clk),
    .load  (accept),
    .level (in_lvl),
    .cfg   (aper_cfg),
    .limit (limit)
  );

  snap_mem #(
    .LEVELS(LEVELS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (req_lvl),
    .wr_data (req),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`ifndef SYNTHESIS
  // A result appears only right after the store read of a resolve.
  a_done_after_res: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == snap_pkg::ST_RES))
    else $error("result strobe without a resolve read");

  // The decide cycle comes only at the end of the full aperture pipeline.
  a_dec_after_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == snap_pkg::ST_DEC) |-> $past(state == snap_pkg::ST_AP3))
    else $error("decision taken before the aperture limit settled");

  // A hit is reported only when some level was valid during the resolve read.
  a_hit_has_entry: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> $past(|level_valid))
    else $error("hit reported with no valid level");
`endif

endmodule

`default_nettype wire

// ----- sim/snap_candidate_selector_unit_test.sv -----
// Self-checking testbench for snap_candidate_selector_unit: directed table, then random bursts.
// Predicts resolve answers from its copy of the level store and registers, or from the table.
// Depends on snap_pkg (command and register codes, reset values) and the design files.
`default_nettype none

module snap_candidate_selector_unit_test;

  localparam int LEVEL_COUNT = 16;
  // The block takes func 3 and does nothing with it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // A consider item keeps busy high through its decide cycle; this adds margin on top.
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 280;

  // One command item as it goes onto the command port.
  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  kind;
    logic [7:0]  prio;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [63:0] obj;
    logic [63:0] partner;
    logic [23:0] dist_val;
  } cmd_t;

  // One resolve answer. It also serves as the stored entry of a level, with hit set.
  typedef struct packed {
    logic        hit;
    logic [4:0]  kind;
    logic [7:0]  prio;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [63:0] obj;
    logic [63:0] partner;
  } result_t;

  // One row of the directed table. When typed is set, want is the answer we expect.
  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t want;
  } row_t;

  localparam result_t NO_HIT = '0;
  localparam cmd_t RESOLVE_CMD = '{func: snap_pkg::FUNC_RESOLVE, default: '0};
  localparam cmd_t CLEAR_CMD = '{func: snap_pkg::FUNC_CLEAR, default: '0};
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = snap_pkg::FUNC_CONSIDER;
  logic [4:0]         kind = '0;
  logic [7:0]         priority_req = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic [63:0]        object_id = '0;
  logic [63:0]        partner_id = '0;
  logic [23:0]        distance = '0;
  logic               done;
  logic               hit;
  logic [4:0]         out_kind;
  logic [7:0]         out_priority;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [63:0]        out_object;
  logic [63:0]        out_partner;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  snap_candidate_selector_unit #(
    .LEVELS(LEVEL_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .kind(kind),
    .priority_req(priority_req),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .object_id(object_id),
    .partner_id(partner_id),
    .distance(distance),
    .done(done),
    .hit(hit),
    .out_kind(out_kind),
    .out_priority(out_priority),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_object(out_object),
    .out_partner(out_partner),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Our own copy of the registers and of the per-level store.
  logic [31:0] cfg_kind_mask = snap_pkg::KIND_MASK_RST;
  logic [15:0] cfg_aper_max = snap_pkg::APER_MAX_RST;
  logic [15:0] cfg_aper_min = snap_pkg::APER_MIN_RST;
  logic [11:0] cfg_dpi = snap_pkg::DPI_SCALE_RST;
  logic        lvl_valid [LEVEL_COUNT];
  logic [23:0] lvl_dist [LEVEL_COUNT];
  result_t     lvl_entry [LEVEL_COUNT];

  // Answers of accepted resolve items, oldest first, waiting for their done strobe.
  result_t resolve_answers [$];
  row_t    plan [$];

  int errors = 0;
  int items_sent = 0;
  int kept_count = 0;
  int resolve_count = 0;
  int hit_count = 0;
  int gap_pct = 0;
  int quiet_cycles = 0;
  result_t seen_answer;

  initial begin
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      lvl_valid[i] = 1'b0;
      lvl_dist[i] = '1;
      lvl_entry[i] = '0;
    end
  end

  // Priority is clamped to the top level; level zero is the ambient grid and never kept.
  function automatic int unsigned level_of(input logic [7:0] prio);
    return (prio < LEVEL_COUNT - 1) ? prio : LEVEL_COUNT - 1;
  endfunction

  // The capture radius of a level as a Q12.16 product of the aperture and the scale.
  // The aperture falls (or rises, when min is above max) linearly from level one to the
  // top level, with the per-level drop truncated toward zero. A zero scale counts as 1.0.
  function automatic logic [63:0] reach_limit(input int unsigned lvl);
    longint drop;
    longint aper;
    logic [63:0] scale;
    drop = (longint'(lvl) - 1) * (longint'(cfg_aper_max) - longint'(cfg_aper_min))
           / (LEVEL_COUNT - 2);
    aper = longint'(cfg_aper_max) - drop;
    scale = (cfg_dpi == '0) ? snap_pkg::DPI_SCALE_ONE : cfg_dpi;
    return {32'd0, aper[31:0]} * scale;
  endfunction

  // Applies one accepted item to the local store. Returns 1 when the item gives an answer.
  function automatic bit apply_command(input cmd_t c, output result_t answer);
    int unsigned lvl;
    answer = NO_HIT;
    case (c.func)
      snap_pkg::FUNC_CONSIDER: begin
        if (c.kind == '0 || !cfg_kind_mask[c.kind]) return 1'b0;
        lvl = level_of(c.prio);
        if (lvl == 0) return 1'b0;
        // The distance gets eight more fraction bits to line up with the Q12.16 radius.
        if ({c.dist_val, 8'd0} > reach_limit(lvl)) return 1'b0;
        // Only a strictly nearer point displaces the one already kept.
        if (lvl_valid[lvl] && c.dist_val >= lvl_dist[lvl]) return 1'b0;
        lvl_valid[lvl] = 1'b1;
        lvl_dist[lvl] = c.dist_val;
        lvl_entry[lvl] = '{1'b1, c.kind, c.prio, c.x, c.y, c.z, c.obj, c.partner};
        kept_count++;
        return 1'b0;
      end
      snap_pkg::FUNC_CLEAR: begin
        // Clear drops the valid bits and distances only; the stored fields stay.
        for (int i = 0; i < LEVEL_COUNT; i++) begin
          lvl_valid[i] = 1'b0;
          lvl_dist[i] = '1;
        end
        return 1'b0;
      end
      snap_pkg::FUNC_RESOLVE: begin
        resolve_count++;
        for (int i = LEVEL_COUNT - 1; i >= 1; i--) begin
          if (lvl_valid[i]) begin
            answer = lvl_entry[i];
            hit_count++;
            break;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void set_register(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      snap_pkg::REG_KIND_MASK: cfg_kind_mask = value;
      snap_pkg::REG_APER_MAX:  cfg_aper_max = value[15:0];
      snap_pkg::REG_APER_MIN:  cfg_aper_min = value[15:0];
      snap_pkg::REG_DPI_SCALE: cfg_dpi = value[11:0];
      default: ;
    endcase
  endfunction

  // A consider item with random content. Most distances lie from zero to just past the
  // capture radius of its level, some repeat the kept distance exactly, the rest are anywhere.
  function automatic cmd_t random_candidate();
    cmd_t c;
    int unsigned lvl;
    int unsigned roll;
    logic [63:0] reach;
    logic [31:0] top;
    c.func = snap_pkg::FUNC_CONSIDER;
    c.kind = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    roll = $urandom_range(0, 9);
    c.prio = (roll == 0) ? 8'd0 :
             (roll == 1) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(1, 15));
    c.x = $urandom;
    c.y = $urandom;
    c.z = $urandom;
    c.obj = {$urandom, $urandom};
    c.partner = {$urandom, $urandom};
    lvl = level_of(c.prio);
    reach = reach_limit(lvl) >> 8;
    top = (reach >= 64'hFF_FFFF) ? 32'hFF_FFFF : 32'(reach) + 32'd1;
    roll = $urandom_range(0, 9);
    if (roll < 3)
      c.dist_val = 24'($urandom);
    else if (roll == 3 && lvl_valid[lvl])
      c.dist_val = lvl_dist[lvl];
    else
      c.dist_val = 24'($urandom_range(0, top));
    return c;
  endfunction

  // Offers one item and waits until the block takes it. start is left high afterwards so
  // that a following item goes out without a gap; only an idle stretch or a drain lowers it.
  task automatic issue(input cmd_t c, input bit typed, input result_t want);
    result_t predicted;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    func <= c.func;
    kind <= c.kind;
    priority_req <= c.prio;
    coord_x <= c.x;
    coord_y <= c.y;
    coord_z <= c.z;
    object_id <= c.obj;
    partner_id <= c.partner;
    distance <= c.dist_val;
    do @(posedge clk); while (busy !== 1'b0);
    if (apply_command(c, predicted))
      resolve_answers.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Holds the sender off until every answer is in, then lets a consider item
  // that may still be running finish.
  task automatic drain_answers();
    start <= 1'b0;
    while (resolve_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write and a read back of the same register. psel stays high so that a
  // following transfer can start right away.
  task automatic write_and_verify(input logic [1:0] idx, input logic [31:0] value,
                                  input logic [31:0] width_mask);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    set_register(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    if ((readback & width_mask) !== (value & width_mask)) begin
      $display("%0t: register %0d read back expected %h got %h", $time, idx,
               value & width_mask, readback & width_mask);
      errors++;
    end
  endtask

  task automatic program_registers(input logic [31:0] mask, input logic [15:0] amax,
                                   input logic [15:0] amin, input logic [11:0] scale);
    drain_answers();
    write_and_verify(snap_pkg::REG_KIND_MASK, mask, 32'hFFFF_FFFF);
    write_and_verify(snap_pkg::REG_APER_MAX, {16'd0, amax}, 32'h0000_FFFF);
    write_and_verify(snap_pkg::REG_APER_MIN, {16'd0, amin}, 32'h0000_FFFF);
    write_and_verify(snap_pkg::REG_DPI_SCALE, {20'd0, scale}, 32'h0000_0FFF);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Answers cannot be held off, so every done strobe is taken at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (resolve_answers.size() == 0) begin
        $display("%0t: answer with hit %b kind %h arrived with nothing expected",
                 $time, hit, out_kind);
        errors++;
      end else begin
        seen_answer = resolve_answers.pop_front();
        check_field("hit", {63'd0, seen_answer.hit}, {63'd0, hit});
        check_field("out_kind", {59'd0, seen_answer.kind}, {59'd0, out_kind});
        check_field("out_priority", {56'd0, seen_answer.prio}, {56'd0, out_priority});
        check_field("out_x", {32'd0, seen_answer.x}, {32'd0, out_x});
        check_field("out_y", {32'd0, seen_answer.y}, {32'd0, out_y});
        check_field("out_z", {32'd0, seen_answer.z}, {32'd0, out_z});
        check_field("out_object", seen_answer.obj, out_object);
        check_field("out_partner", seen_answer.partner, out_partner);
      end
    end
  end

  // Ends a hung run: counts cycles in which no item, answer or register write goes through.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("snap_candidate_selector_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned roll;
    int unsigned random_done;
    cmd_t noise;

    // Directed part, under the reset values of the registers. At level one the radius
    // is 16.0 pixels (distance 4096), at the top level 4.0 pixels (distance 1024).
    plan = '{
      '{RESOLVE_CMD, 1'b1, NO_HIT},
      // Kind zero is never kept.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd0, 8'd5, 32'd1, 32'd2, 32'd3, 64'd4, 64'd5,
               24'd0}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, NO_HIT},
      // Priority zero is the ambient grid level, which is never kept.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd31, 8'd0, 32'd1, 32'd2, 32'd3, 64'd4, 64'd5,
               24'd0}, 1'b0, NO_HIT},
      // Just outside the top level's radius.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd31, 8'd255, 32'd1, 32'd2, 32'd3, 64'd4, 64'd5,
               24'd1025}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, NO_HIT},
      // Right on the radius, extreme field values, priority clamped to the top level.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd31, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF, ALL_ONES, ALL_ONES, 24'd1024}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, result_t'{1'b1, 5'd31, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'hFFFF_FFFF, ALL_ONES, ALL_ONES}},
      // An equal distance does not displace the kept point.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd1, 8'd15, 32'd9, 32'd9, 32'd9, 64'd9, 64'd9,
               24'd1024}, 1'b0, NO_HIT},
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd2, 8'd15, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0,
               24'd0}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, result_t'{1'b1, 5'd2, 8'd15, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0}},
      // A lower level never wins over a higher one.
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd3, 8'd1, 32'd5, 32'd6, 32'd7, 64'd8, 64'd9,
               24'd4096}, 1'b0, NO_HIT},
      '{cmd_t'{FUNC_UNUSED, 5'd31, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               ALL_ONES, ALL_ONES, 24'hFF_FFFF}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, result_t'{1'b1, 5'd2, 8'd15, 32'd0, 32'd0, 32'd0, 64'd0, 64'd0}},
      '{CLEAR_CMD, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, NO_HIT},
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd3, 8'd1, 32'h1234_5678, 32'hDEAD_BEEF,
               32'h8000_0001, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 24'd4096},
        1'b0, NO_HIT},
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd4, 8'd1, 32'd1, 32'd1, 32'd1, 64'd1, 64'd1,
               24'd4097}, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b0, NO_HIT},
      '{cmd_t'{snap_pkg::FUNC_CONSIDER, 5'd16, 8'd200, 32'hAAAA_5555, 32'h5555_AAAA,
               32'h0F0F_F0F0, 64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA, 24'd100},
        1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b0, NO_HIT},
      '{CLEAR_CMD, 1'b0, NO_HIT},
      '{RESOLVE_CMD, 1'b1, NO_HIT}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 31;
    foreach (plan[i]) issue(plan[i].cmd, plan[i].typed, plan[i].want);

    // Random part. Each phase runs under one register setting: first the reset values,
    // then extremes and special cases, then random settings. Most traffic is bursts of
    // candidates closed by a resolve; clears, noise items and full drains are mixed in.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: program_registers(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 12'hFFF);
        // Aperture rising with the level, and a zero scale that acts as 1.0.
        2: program_registers($urandom, 16'h0000, 16'hFFFF, 12'h000);
        // Zero radius: only a distance of zero gets in, and only for kind 31.
        3: program_registers(32'h8000_0001, 16'h0000, 16'h0000, 12'h001);
        default: program_registers($urandom, 16'($urandom), 16'($urandom), 12'($urandom));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // The sender idles often, then very often, then not at all.
        random_done = phase * PHASE_ITEMS + sent;
        gap_pct = (random_done < PHASES * PHASE_ITEMS / 3) ? 31 :
                  (random_done < 2 * PHASES * PHASE_ITEMS / 3) ? 82 : 0;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          drain_answers();
        end else if (roll < 10) begin
          issue(CLEAR_CMD, 1'b0, NO_HIT);
          sent++;
        end else if (roll < 16) begin
          noise.func = 2'($urandom);
          noise.kind = 5'($urandom);
          noise.prio = 8'($urandom);
          noise.x = $urandom;
          noise.y = $urandom;
          noise.z = $urandom;
          noise.obj = {$urandom, $urandom};
          noise.partner = {$urandom, $urandom};
          noise.dist_val = 24'($urandom);
          issue(noise, 1'b0, NO_HIT);
          if (noise.func != FUNC_UNUSED) sent++;
        end else begin
          burst = $urandom_range(1, 8);
          repeat (burst) issue(random_candidate(), 1'b0, NO_HIT);
          issue(RESOLVE_CMD, 1'b0, NO_HIT);
          sent += burst + 1;
        end
      end
    end

    drain_answers();
    $display("Sent %0d items under %0d register settings: %0d candidates kept,",
             items_sent, PHASES, kept_count);
    $display("%0d resolves answered, %0d of them with a hit.", resolve_count, hit_count);
    if (errors == 0) begin
      $display("snap_candidate_selector_unit test passed");
    end else begin
      $display("snap_candidate_selector_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
